// ----- design/two_tier_watermark_lru_evictor_assert.svh -----
// Assertion macros shared by the evictor RTL.
`ifndef TWO_TIER_WATERMARK_LRU_EVICTOR_ASSERT_SVH
`define TWO_TIER_WATERMARK_LRU_EVICTOR_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define TWLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("evictor assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define TWLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("evictor assertion failed");

`endif

// ----- design/twle_pkg.sv -----
`timescale 1ns / 1ps
package twle_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MAKE  = 2'd1;
    localparam logic [1:0] OP_TRIM  = 2'd2;

    localparam logic [2:0] ST_ABSENT       = 3'd0;
    localparam logic [2:0] ST_HOST_READY   = 3'd2;
    localparam logic [2:0] ST_DEVICE_READY = 3'd4;

    localparam logic [2:0] CFG_HOST_HIGH = 3'd0;
    localparam logic [2:0] CFG_HOST_LOW  = 3'd1;
    localparam logic [2:0] CFG_DEV_HIGH  = 3'd2;
    localparam logic [2:0] CFG_DEV_LOW   = 3'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic        pinned;
        logic        has_host;
        logic        has_device;
        logic [39:0] host_bytes;
        logic [39:0] device_bytes;
        logic [31:0] age;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ----- design/twle_ram.sv -----
`timescale 1ns / 1ps
module twle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/two_tier_watermark_lru_evictor.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_        in         tuser: opcode; tdata: slot, host_need, device_need, new_* fields
// m_        out        tdata: granted, evictions, freed_bytes, host_in_use, device_in_use
// cfg_      in         register index and 48-bit write data, no read-back
//
// After reset every slot of the memory is cleared before the first word is taken.
// A refused request answers in the cycle after acceptance; a write answers from S_WRITE and a
// request that already fits from S_DECIDE. An eviction round runs through S_DECIDE, S_SCAN
// over the memory's single read port, S_SCAN_END for the last word and S_EVICT for write-back.
// Make capacity ends in S_DECIDE or on a round that finds no victim; trim ends on a round that
// finds no victim. One word is in flight; the next is accepted only once its result is taken.
module two_tier_watermark_lru_evictor #(
    parameter int SLOT_COUNT = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // slot, host_need, device_need, new_status, new_pinned, new_has_host,
    // new_has_device, new_host_bytes, new_device_bytes, new_age_stamp
    input  logic [207:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // granted, evictions, freed_bytes, host_in_use, device_in_use
    output logic [159:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] LAST = CW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_DECIDE, S_SCAN, S_SCAN_END, S_EVICT
    } state_t;

    typedef enum logic [1:0] { M_DRAIN_HIGH, M_DRAIN_LOW, M_TRIM } mode_t;

    state_t state_reg;
    mode_t  mode_reg;

    logic [47:0] hh_reg, hl_reg, dh_reg, dl_reg;
    logic [47:0] ht_reg, dt_reg, freed_reg;
    logic [7:0]  evict_reg;
    logic        granted_reg, m_valid_reg;
    logic [CW-1:0] cnt_reg;
    logic        dv_reg;
    logic [IW-1:0] didx_reg;
    logic        wh_reg, wd_reg;
    logic        excl_v_reg;
    logic [IW-1:0] excl_reg;
    logic [39:0] hn_reg, dn_reg;
    twle_pkg::slot_entry_t new_reg, best_reg;
    logic [IW-1:0] wslot_reg;
    logic        wslot_ok_reg;
    logic        best_found_reg;
    logic [IW-1:0] best_idx_reg;

    // Input fields.
    logic [5:0]  in_slot;
    logic [39:0] in_hn, in_dn;
    twle_pkg::slot_entry_t in_entry;
    assign in_slot             = s_tdata[5:0];
    assign in_hn               = s_tdata[45:6];
    assign in_dn               = s_tdata[85:46];
    assign in_entry.status       = s_tdata[88:86];
    assign in_entry.pinned       = s_tdata[89];
    assign in_entry.has_host     = s_tdata[90];
    assign in_entry.has_device   = s_tdata[91];
    assign in_entry.host_bytes   = s_tdata[131:92];
    assign in_entry.device_bytes = s_tdata[171:132];
    assign in_entry.age          = s_tdata[203:172];

    logic in_slot_ok;
    logic [IW-1:0] in_slot_idx;
    logic [31:0] in_slot_ext;
    assign in_slot_ext = 32'(in_slot);
    assign in_slot_ok  = in_slot_ext < 32'(SLOT_COUNT);
    assign in_slot_idx = in_slot_ext[IW-1:0];

    // Slot memory.
    logic ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    twle_pkg::slot_entry_t ram_wdata, ram_rdata;

    twle_ram #(.WIDTH(twle_pkg::ENTRY_W), .DEPTH(SLOT_COUNT)) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Watermark tests on the current totals.
    logic over_high, low_h, low_d, need_h, need_d;
    assign over_high = ({1'b0, ht_reg} + {9'b0, hn_reg}) > {1'b0, hh_reg} ||
                       ({1'b0, dt_reg} + {9'b0, dn_reg}) > {1'b0, dh_reg};
    assign need_h = ({1'b0, ht_reg} + {9'b0, hn_reg}) > {1'b0, hl_reg};
    assign need_d = ({1'b0, dt_reg} + {9'b0, dn_reg}) > {1'b0, dl_reg};
    assign low_h  = ht_reg > hl_reg;
    assign low_d  = dt_reg > dl_reg;

    // Candidate test on the word returned by the scan.
    logic cand, better;
    always_comb begin
        cand = dv_reg && !(excl_v_reg && didx_reg == excl_reg) && !ram_rdata.pinned &&
               (ram_rdata.status == twle_pkg::ST_ABSENT ||
                ram_rdata.status == twle_pkg::ST_HOST_READY ||
                ram_rdata.status == twle_pkg::ST_DEVICE_READY) &&
               ((wh_reg && ram_rdata.has_host) || (wd_reg && ram_rdata.has_device));
        better = cand && (!best_found_reg || ram_rdata.age < best_reg.age);
    end

    // Victim after release.
    logic rel_h, rel_d;
    twle_pkg::slot_entry_t victim;
    always_comb begin
        rel_h  = wh_reg && best_reg.has_host;
        rel_d  = wd_reg && best_reg.has_device;
        victim = best_reg;
        if (rel_h) begin
            victim.host_bytes = '0;
            victim.has_host   = 1'b0;
        end
        if (rel_d) begin
            victim.device_bytes = '0;
            victim.has_device   = 1'b0;
            if (best_reg.status == twle_pkg::ST_DEVICE_READY) begin
                victim.status = victim.has_host ? twle_pkg::ST_HOST_READY
                                                : twle_pkg::ST_ABSENT;
            end
        end
        if (victim.status == twle_pkg::ST_HOST_READY && !victim.has_host) begin
            victim.status = twle_pkg::ST_ABSENT;
        end
    end

    logic [47:0] rel_hb, rel_db;
    assign rel_hb = rel_h ? {8'b0, best_reg.host_bytes} : 48'b0;
    assign rel_db = rel_d ? {8'b0, best_reg.device_bytes} : 48'b0;

    logic s_acc;
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = didx_reg;
        ram_wdata = victim;
        ram_raddr = cnt_reg[IW-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[IW-1:0];
                ram_wdata = '0;
            end
            S_IDLE:  ram_raddr = in_slot_idx;
            S_WRITE: begin
                ram_we    = wslot_ok_reg;
                ram_waddr = wslot_reg;
                ram_wdata = new_reg;
            end
            S_EVICT: begin
                ram_we    = best_found_reg;
                ram_waddr = best_idx_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            mode_reg       <= M_TRIM;
            hh_reg         <= '1;
            hl_reg         <= '0;
            dh_reg         <= '1;
            dl_reg         <= '0;
            ht_reg         <= '0;
            dt_reg         <= '0;
            freed_reg      <= '0;
            evict_reg      <= '0;
            granted_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            dv_reg         <= 1'b0;
            best_found_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    twle_pkg::CFG_HOST_HIGH: hh_reg <= cfg_wdata;
                    twle_pkg::CFG_HOST_LOW:  hl_reg <= cfg_wdata;
                    twle_pkg::CFG_DEV_HIGH:  dh_reg <= cfg_wdata;
                    twle_pkg::CFG_DEV_LOW:   dl_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            dv_reg   <= 1'b0;
            didx_reg <= cnt_reg[IW-1:0];
            if (better) begin
                best_found_reg <= 1'b1;
                best_reg       <= ram_rdata;
                best_idx_reg   <= didx_reg;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        evict_reg    <= '0;
                        freed_reg    <= '0;
                        hn_reg       <= in_hn;
                        dn_reg       <= in_dn;
                        new_reg      <= in_entry;
                        wslot_reg    <= in_slot_idx;
                        wslot_ok_reg <= in_slot_ok;
                        excl_reg     <= in_slot_idx;
                        excl_v_reg   <= in_slot_ok;
                        granted_reg  <= 1'b1;
                        case (s_tuser)
                            twle_pkg::OP_WRITE: state_reg <= S_WRITE;
                            twle_pkg::OP_MAKE: begin
                                mode_reg  <= M_DRAIN_HIGH;
                                state_reg <= S_DECIDE;
                                if ({8'b0, in_hn} > hh_reg || {8'b0, in_dn} > dh_reg) begin
                                    granted_reg <= 1'b0;
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= S_IDLE;
                                end else begin
                                    granted_reg <= 1'b1;
                                end
                            end
                            twle_pkg::OP_TRIM: begin
                                mode_reg   <= M_TRIM;
                                excl_v_reg <= 1'b0;
                                state_reg  <= S_DECIDE;
                            end
                            default: m_valid_reg <= 1'b1;
                        endcase
                    end
                end
                S_WRITE: begin
                    if (wslot_ok_reg) begin
                        ht_reg <= ht_reg - {8'b0, ram_rdata.host_bytes} +
                                  {8'b0, new_reg.host_bytes};
                        dt_reg <= dt_reg - {8'b0, ram_rdata.device_bytes} +
                                  {8'b0, new_reg.device_bytes};
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                S_DECIDE: begin
                    cnt_reg        <= '0;
                    best_found_reg <= 1'b0;
                    unique case (mode_reg)
                        M_DRAIN_HIGH: begin
                            if (!over_high) begin
                                // A request that already fits finishes without draining.
                                if (evict_reg == 8'd0) begin
                                    granted_reg <= 1'b1;
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= S_IDLE;
                                end else begin
                                    mode_reg <= M_DRAIN_LOW;
                                end
                            end else begin
                                wh_reg    <= need_h;
                                wd_reg    <= need_d;
                                state_reg <= S_SCAN;
                            end
                        end
                        M_DRAIN_LOW: begin
                            if (!low_h && !low_d) begin
                                granted_reg <= !over_high;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else begin
                                wh_reg    <= low_h;
                                wd_reg    <= low_d;
                                state_reg <= S_SCAN;
                            end
                        end
                        default: begin
                            wh_reg    <= 1'b1;
                            wd_reg    <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    endcase
                end
                S_SCAN: begin
                    dv_reg  <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST) begin
                        state_reg <= S_SCAN_END;
                    end
                end
                S_SCAN_END: state_reg <= S_EVICT;
                S_EVICT: begin
                    if (best_found_reg) begin
                        ht_reg    <= ht_reg - rel_hb;
                        dt_reg    <= dt_reg - rel_db;
                        freed_reg <= freed_reg + rel_hb + rel_db;
                        if (evict_reg != 8'hFF) begin
                            evict_reg <= evict_reg + 1'b1;
                        end
                        state_reg <= S_DECIDE;
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        unique case (mode_reg)
                            M_DRAIN_HIGH: granted_reg <= 1'b0;
                            M_DRAIN_LOW:  granted_reg <= !over_high;
                            default:      granted_reg <= 1'b1;
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, dt_reg, ht_reg, freed_reg, evict_reg, granted_reg};

    `include "two_tier_watermark_lru_evictor_assert.svh"

    `TWLE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `TWLE_ASSERT_NEXT(a_round_counts, state_reg == S_EVICT && best_found_reg,
                      evict_reg == 8'hFF || evict_reg == $past(evict_reg) + 8'd1)
    `TWLE_ASSERT_NOW(a_write_states, ram_we,
                     state_reg == S_CLEAR || state_reg == S_WRITE || state_reg == S_EVICT)

endmodule

// ----- tb/two_tier_watermark_lru_evictor_tb.sv -----
`timescale 1ns / 1ps
module two_tier_watermark_lru_evictor_tb;

    localparam int SLOTS = 64;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic [2:0] ST_LOADING = 3'd1;
    localparam logic [2:0] ST_UPLOADING = 3'd3;
    localparam logic [2:0] ST_FAILED = 3'd5;
    localparam logic [47:0] ALL_ONES48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] ALL_ONES40 = 40'hFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 60000000;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  slot;
        logic [39:0] host_need;
        logic [39:0] dev_need;
        logic [2:0]  status;
        logic        pinned;
        logic        has_host;
        logic        has_dev;
        logic [39:0] host_bytes;
        logic [39:0] dev_bytes;
        logic [31:0] age;
    } request_t;

    typedef struct {
        logic        granted;
        logic [7:0]  evictions;
        logic [47:0] freed;
        logic [47:0] host_use;
        logic [47:0] dev_use;
    } answer_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [1:0] s_tuser = '0;
    logic [207:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [159:0] m_tdata;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_index = '0;
    logic [47:0] cfg_wdata = '0;

    two_tier_watermark_lru_evictor #(.SLOT_COUNT(SLOTS)) dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Predictor copy of the slot table, totals and watermarks.
    logic [2:0]  tbl_status [SLOTS];
    logic        tbl_pinned [SLOTS];
    logic        tbl_has_host [SLOTS];
    logic        tbl_has_dev [SLOTS];
    logic [39:0] tbl_host_bytes [SLOTS];
    logic [39:0] tbl_dev_bytes [SLOTS];
    logic [31:0] tbl_age [SLOTS];
    logic [47:0] host_sum = '0, dev_sum = '0;
    logic [47:0] host_hi = ALL_ONES48, host_lo = '0, dev_hi = ALL_ONES48, dev_lo = '0;
    int rounds_done;
    longint unsigned bytes_released;

    request_t pending_reqs[$];
    answer_t expected_answers[$];
    request_t cur_req;
    int errors = 0;
    int tx_idle = 0, rx_idle = 0;
    int answers_seen = 0;
    int hold_left = 0;
    bit hold_done = 0;
    longint cycles = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_status[i] = twle_pkg::ST_ABSENT;
            tbl_pinned[i] = 0;
            tbl_has_host[i] = 0;
            tbl_has_dev[i] = 0;
            tbl_host_bytes[i] = '0;
            tbl_dev_bytes[i] = '0;
            tbl_age[i] = '0;
        end
    end

    function automatic void enqueue(request_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic bit evict_oldest(bit want_h, bit want_d, int excl);
        int pick;
        bit found;
        logic [2:0] st;
        pick = 0;
        found = 0;
        for (int i = 0; i < SLOTS; i++) begin
            st = tbl_status[i];
            if (i == excl || tbl_pinned[i]) continue;
            if (st != twle_pkg::ST_ABSENT && st != twle_pkg::ST_HOST_READY &&
                st != twle_pkg::ST_DEVICE_READY) continue;
            if (!((want_h && tbl_has_host[i]) || (want_d && tbl_has_dev[i]))) continue;
            if (!found || tbl_age[i] < tbl_age[pick]) begin
                pick = i;
                found = 1;
            end
        end
        if (!found) return 1'b0;
        if (want_h && tbl_has_host[pick]) begin
            host_sum = host_sum - tbl_host_bytes[pick];
            bytes_released += tbl_host_bytes[pick];
            tbl_host_bytes[pick] = '0;
            tbl_has_host[pick] = 0;
        end
        if (want_d && tbl_has_dev[pick]) begin
            dev_sum = dev_sum - tbl_dev_bytes[pick];
            bytes_released += tbl_dev_bytes[pick];
            tbl_dev_bytes[pick] = '0;
            tbl_has_dev[pick] = 0;
            if (tbl_status[pick] == twle_pkg::ST_DEVICE_READY)
                tbl_status[pick] = tbl_has_host[pick] ? twle_pkg::ST_HOST_READY
                                                      : twle_pkg::ST_ABSENT;
        end
        if (tbl_status[pick] == twle_pkg::ST_HOST_READY && !tbl_has_host[pick])
            tbl_status[pick] = twle_pkg::ST_ABSENT;
        rounds_done++;
        return 1'b1;
    endfunction

    function automatic bit above_high(logic [39:0] hn, logic [39:0] dn);
        return ({16'd0, host_sum} + hn > {16'd0, host_hi}) ||
               ({16'd0, dev_sum} + dn > {16'd0, dev_hi});
    endfunction

    function automatic logic make_room(logic [39:0] hn, logic [39:0] dn, int excl);
        bit pressured;
        if ({8'd0, hn} > host_hi || {8'd0, dn} > dev_hi) return 1'b0;
        pressured = above_high(hn, dn);
        while (above_high(hn, dn)) begin
            if (!evict_oldest({16'd0, host_sum} + hn > {16'd0, host_lo},
                              {16'd0, dev_sum} + dn > {16'd0, dev_lo}, excl))
                return 1'b0;
        end
        if (pressured) begin
            while ((host_sum > host_lo || dev_sum > dev_lo) &&
                   evict_oldest(host_sum > host_lo, dev_sum > dev_lo, excl)) begin
            end
        end
        return above_high(hn, dn) ? 1'b0 : 1'b1;
    endfunction

    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int s;
        s = r.slot;
        a.granted = 1;
        rounds_done = 0;
        bytes_released = 0;
        case (r.op)
            twle_pkg::OP_WRITE: begin
                host_sum = host_sum - tbl_host_bytes[s] + r.host_bytes;
                dev_sum = dev_sum - tbl_dev_bytes[s] + r.dev_bytes;
                tbl_status[s] = r.status;
                tbl_pinned[s] = r.pinned;
                tbl_has_host[s] = r.has_host;
                tbl_has_dev[s] = r.has_dev;
                tbl_host_bytes[s] = r.host_bytes;
                tbl_dev_bytes[s] = r.dev_bytes;
                tbl_age[s] = r.age;
            end
            twle_pkg::OP_MAKE: a.granted = make_room(r.host_need, r.dev_need, s);
            twle_pkg::OP_TRIM: while (evict_oldest(1, 1, SLOTS)) begin
            end
            default: ;
        endcase
        a.evictions = rounds_done > 255 ? 8'd255 : rounds_done[7:0];
        a.freed = bytes_released[47:0];
        a.host_use = host_sum;
        a.dev_use = dev_sum;
        return a;
    endfunction

    // Driver: a new word is presented once the previous one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_answers.insert(expected_answers.size(), apply_request(cur_req));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle) begin
                cur_req = pending_reqs.pop_front();
                s_tuser <= cur_req.op;
                s_tdata <= {4'd0, cur_req.age, cur_req.dev_bytes, cur_req.host_bytes,
                            cur_req.has_dev, cur_req.has_host, cur_req.pinned,
                            cur_req.status, cur_req.dev_need, cur_req.host_need,
                            cur_req.slot};
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        answer_t exp_a;
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
                report("unexpected word", m_tdata[63:0], 64'd0);
            end else begin
                exp_a = expected_answers.pop_front();
                if (m_tdata[0] !== exp_a.granted) report("granted", m_tdata[0], exp_a.granted);
                if (m_tdata[8:1] !== exp_a.evictions)
                    report("evictions", m_tdata[8:1], exp_a.evictions);
                if (m_tdata[56:9] !== exp_a.freed) report("freed_bytes", m_tdata[56:9], exp_a.freed);
                if (m_tdata[104:57] !== exp_a.host_use)
                    report("host_in_use", m_tdata[104:57], exp_a.host_use);
                if (m_tdata[152:105] !== exp_a.dev_use)
                    report("device_in_use", m_tdata[152:105], exp_a.dev_use);
            end
        end
        m_tready <= aresetn && hold_left == 0 && $urandom_range(99) >= rx_idle;
    end

    // One long receiver stall while the sender keeps offering words.
    always @(posedge aclk) begin
        if (!hold_done && answers_seen >= 150) begin
            hold_left <= 600;
            hold_done <= 1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [39:0] rand_bytes(int span);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return 40'({$urandom, $urandom} & {24'd0, ALL_ONES40});
        if (pick < 15) return '0;
        return 40'($urandom_range(span));
    endfunction

    function automatic request_t rand_request();
        request_t r;
        int pick;
        pick = $urandom_range(99);
        r.op = pick < 55 ? twle_pkg::OP_WRITE : pick < 88 ? twle_pkg::OP_MAKE :
               pick < 95 ? twle_pkg::OP_TRIM : OP_NOP;
        r.slot = 6'($urandom_range(SLOTS - 1));
        r.host_need = rand_bytes(3000);
        r.dev_need = rand_bytes(3000);
        if ($urandom_range(9) < 7) begin
            pick = $urandom_range(2);
            r.status = pick == 0 ? twle_pkg::ST_ABSENT : pick == 1 ? twle_pkg::ST_HOST_READY
                                                                   : twle_pkg::ST_DEVICE_READY;
        end else begin
            r.status = 3'($urandom_range(7));
        end
        r.pinned = $urandom_range(4) == 0;
        r.has_host = 1'($urandom_range(1));
        r.has_dev = 1'($urandom_range(1));
        r.host_bytes = rand_bytes(1500);
        r.dev_bytes = rand_bytes(1500);
        r.age = $urandom_range(3) == 0 ? $urandom : $urandom_range(40);
        return r;
    endfunction

    function automatic request_t slot_write(int s, logic [2:0] st, logic pin, logic hh,
                                            logic hd, logic [39:0] hb, logic [39:0] db,
                                            logic [31:0] age);
        request_t r;
        r = '{op: twle_pkg::OP_WRITE, slot: 6'(s), host_need: '0, dev_need: '0, status: st,
              pinned: pin, has_host: hh, has_dev: hd, host_bytes: hb, dev_bytes: db,
              age: age};
        return r;
    endfunction

    function automatic request_t cap_request(logic [1:0] op, int s, logic [39:0] hn,
                                             logic [39:0] dn);
        request_t r;
        r = slot_write(s, twle_pkg::ST_ABSENT, 1'b0, 1'b0, 1'b0, '0, '0, '0);
        r.op = op;
        r.host_need = hn;
        r.dev_need = dn;
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_marks(logic [47:0] hh, logic [47:0] hl, logic [47:0] dh, logic [47:0] dl);
        logic [47:0] vals [4];
        logic [2:0] idx [4];
        vals = '{hh, hl, dh, dl};
        idx = '{twle_pkg::CFG_HOST_HIGH, twle_pkg::CFG_HOST_LOW, twle_pkg::CFG_DEV_HIGH,
                twle_pkg::CFG_DEV_LOW};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 0;
        host_hi = hh;
        host_lo = hl;
        dev_hi = dh;
        dev_lo = dl;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // Directed words under the reset watermarks, then under tight ones.
        tx_idle = 24;
        rx_idle = 77;
        enqueue(slot_write(0, twle_pkg::ST_HOST_READY, 0, 1, 0, ALL_ONES40, '0, '0));
        enqueue(slot_write(63, twle_pkg::ST_DEVICE_READY, 0, 1, 1, 40'd100, ALL_ONES40,
                           32'hFFFF_FFFF));
        enqueue(slot_write(5, twle_pkg::ST_DEVICE_READY, 0, 0, 1, '0, 40'd700, 32'd3));
        enqueue(slot_write(6, twle_pkg::ST_DEVICE_READY, 0, 0, 1, '0, 40'd300, 32'd3));
        enqueue(slot_write(7, twle_pkg::ST_HOST_READY, 1, 1, 0, 40'd900, '0, '0));
        enqueue(slot_write(8, ST_LOADING, 0, 1, 1, 40'd50, 40'd50, '0));
        enqueue(slot_write(9, ST_UPLOADING, 0, 1, 1, 40'd60, 40'd60, '0));
        enqueue(slot_write(10, ST_FAILED, 0, 1, 0, 40'd70, '0, '0));
        enqueue(slot_write(11, 3'd6, 0, 1, 1, 40'd80, 40'd80, '0));
        enqueue(slot_write(12, 3'd7, 0, 1, 1, 40'd90, 40'd90, '0));
        enqueue(slot_write(13, twle_pkg::ST_ABSENT, 0, 1, 0, 40'd20, '0, 32'd1));
        enqueue(cap_request(OP_NOP, 3, 40'd5, 40'd5));
        enqueue(cap_request(twle_pkg::OP_MAKE, 0, ALL_ONES40, ALL_ONES40));
        enqueue(cap_request(twle_pkg::OP_TRIM, 0, '0, '0));
        wait_idle();

        set_marks(48'd2000, 48'd500, 48'd1500, 48'd400);
        enqueue(slot_write(1, twle_pkg::ST_HOST_READY, 0, 1, 0, 40'd800, '0, 32'd5));
        enqueue(slot_write(2, twle_pkg::ST_DEVICE_READY, 0, 1, 1, 40'd600, 40'd900, 32'd5));
        enqueue(slot_write(3, twle_pkg::ST_DEVICE_READY, 0, 0, 1, '0, 40'd500, 32'd2));
        enqueue(slot_write(4, twle_pkg::ST_HOST_READY, 1, 1, 0, 40'd700, '0, '0));
        // Need above a high mark is refused outright.
        enqueue(cap_request(twle_pkg::OP_MAKE, 9, 40'd2001, '0));
        // The request's own slot 2 is excluded from eviction, and the request is refused.
        enqueue(cap_request(twle_pkg::OP_MAKE, 2, '0, 40'd1400));
        enqueue(cap_request(twle_pkg::OP_MAKE, 40, 40'd1000, 40'd1000));
        enqueue(cap_request(twle_pkg::OP_MAKE, 40, 40'd0, 40'd0));
        enqueue(cap_request(twle_pkg::OP_TRIM, 1, '0, '0));
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_marks(48'd3000, 48'd1000, 48'd3000, 48'd1000);
                1: set_marks(ALL_ONES48, 48'd0, 48'd0, 48'd0);
                2: set_marks(48'd0, ALL_ONES48, ALL_ONES48, ALL_ONES48);
                3: set_marks(48'd2500, 48'd4000, 48'd5000, 48'd200);
                4: set_marks(48'($urandom_range(8000)), 48'($urandom_range(3000)),
                             48'($urandom_range(8000)), 48'($urandom_range(3000)));
                default: set_marks(48'd4000, 48'd0, 48'd6000, 48'd2000);
            endcase
            tx_idle = ph < 2 ? 24 : ph < 4 ? 77 : 0;
            rx_idle = ph < 2 ? 77 : ph < 4 ? 24 : 0;
            for (int n = 0; n < 190; n++)
                enqueue(rand_request());
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
